/* sv/gbbc_pkg.sv */
// shared types and constants of the grid bucket best corner block
`default_nettype none

package gbbc_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned CELL_W  = 10;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IW  = 2;

  // largest level shift is seven, so a scaled position needs seven more bits
  localparam int unsigned SHIFT_W = POS_W + 7;
  // row * cols + col with 7-bit operands
  localparam int unsigned IDX_W   = 2 * DIM_W;
  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = POS_W;
  localparam int unsigned DIV_CW    = 4;

  localparam logic [KIND_W-1:0] KIND_MARK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GRID_ROWS = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [SIZE_W-1:0]  RST_CELL_SIZE = 8'd30;
  localparam logic [DIM_W-1:0]   RST_GRID_COLS = 7'd22;
  localparam logic [DIM_W-1:0]   RST_GRID_ROWS = 7'd16;
  localparam logic [SCORE_W-1:0] RST_THRESHOLD = 32'd5120;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
    logic [CELL_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   corner_x;
    logic [POS_W-1:0]   corner_y;
    logic [LEVEL_W-1:0] corner_level;
    logic [SCORE_W-1:0] corner_score;
  } result_t;

  typedef struct packed {
    logic               occupied;
    logic               best_valid;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_INDEX,
    S_READ,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic div_step;
    logic calc_index;
    logic mem_read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic clear_last;
    logic out_busy;
    logic is_read;
  } sts_t;

endpackage

`default_nettype wire

/* sv/gbbc_if.sv */
// request and result channel interfaces
`default_nettype none

interface gbbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [gbbc_pkg::KIND_W-1:0]     kind;
  logic [gbbc_pkg::POS_W-1:0]      pos_x;
  logic [gbbc_pkg::POS_W-1:0]      pos_y;
  logic [gbbc_pkg::LEVEL_W-1:0]    level;
  logic [gbbc_pkg::SCORE_W-1:0]    score;
  logic [gbbc_pkg::CELL_W-1:0]     cell_index;

  modport source (output valid, kind, pos_x, pos_y, level, score, cell_index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, level, score, cell_index, output ready);
endinterface

interface gbbc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [gbbc_pkg::POS_W-1:0]      corner_x;
  logic [gbbc_pkg::POS_W-1:0]      corner_y;
  logic [gbbc_pkg::LEVEL_W-1:0]    corner_level;
  logic [gbbc_pkg::SCORE_W-1:0]    corner_score;

  modport source (output valid, found, corner_x, corner_y, corner_level, corner_score,
                  input ready);
  modport sink   (input valid, found, corner_x, corner_y, corner_level, corner_score,
                  output ready);
endinterface

`default_nettype wire

/* sv/gbbc_ctrl.sv */
// sequencing state machine of the grid bucket block
`default_nettype none

module gbbc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [gbbc_pkg::KIND_W-1:0]   in_kind_i,
  input  wire gbbc_pkg::sts_t                sts_i,
  output gbbc_pkg::cmd_t                     cmd_o,
  output logic                               in_ready_o
);

  gbbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbbc_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbbc_pkg::S_CLEAR: begin
        if (sts_i.clear_last) state_d = gbbc_pkg::S_IDLE;
      end
      gbbc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            gbbc_pkg::KIND_READ: state_d = gbbc_pkg::S_INDEX;
            gbbc_pkg::KIND_MARK: state_d = gbbc_pkg::S_DIV;
            gbbc_pkg::KIND_CAND: state_d = gbbc_pkg::S_DIV;
            default:             state_d = gbbc_pkg::S_IDLE;
          endcase
        end
      end
      gbbc_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = gbbc_pkg::S_INDEX;
      end
      gbbc_pkg::S_INDEX: state_d = gbbc_pkg::S_READ;
      gbbc_pkg::S_READ:  state_d = gbbc_pkg::S_UPDATE;
      gbbc_pkg::S_UPDATE: begin
        if (!(sts_i.is_read && sts_i.out_busy)) state_d = gbbc_pkg::S_IDLE;
      end
      default: state_d = gbbc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gbbc_pkg::S_CLEAR: cmd_o.clear_wr = 1'b1;
      gbbc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gbbc_pkg::S_DIV:    cmd_o.div_step   = 1'b1;
      gbbc_pkg::S_INDEX:  cmd_o.calc_index = 1'b1;
      gbbc_pkg::S_READ:   cmd_o.mem_read   = 1'b1;
      gbbc_pkg::S_UPDATE: cmd_o.commit     = !(sts_i.is_read && sts_i.out_busy);
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // a read result waits for the output register to drain
  a_update_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gbbc_pkg::S_UPDATE && sts_i.is_read && sts_i.out_busy
    |=> state_q == gbbc_pkg::S_UPDATE)
    else $error("update left while result register busy");

  // divider runs its full count before indexing
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gbbc_pkg::S_DIV && !sts_i.div_last |=> state_q == gbbc_pkg::S_DIV)
    else $error("divider cut short");

endmodule

`default_nettype wire

/* sv/gbbc_dp.sv */
// datapath: config, divider, cell index, cell memory and result register
`default_nettype none

module gbbc_dp #(
  parameter int unsigned MAX_CELLS  = 1024,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gbbc_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire logic [gbbc_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire gbbc_pkg::item_t               item_i,
  input  wire gbbc_pkg::cmd_t                cmd_i,
  output gbbc_pkg::sts_t                     sts_o,
  output gbbc_pkg::result_t                  result_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i
);

  localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned PW = gbbc_pkg::POS_W;
  localparam int unsigned IW = gbbc_pkg::IDX_W;
  localparam int unsigned DW = gbbc_pkg::DIM_W;
  localparam int unsigned SW = gbbc_pkg::SIZE_W;

  // configuration registers
  logic [SW-1:0]                    cell_size_q;
  logic [DW-1:0]                    cols_q;
  logic [DW-1:0]                    rows_q;
  logic [gbbc_pkg::SCORE_W-1:0]     thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= gbbc_pkg::RST_CELL_SIZE;
      cols_q      <= gbbc_pkg::RST_GRID_COLS;
      rows_q      <= gbbc_pkg::RST_GRID_ROWS;
      thr_q       <= gbbc_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbbc_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_data_i[SW-1:0];
        gbbc_pkg::CFG_GRID_COLS: cols_q      <= cfg_data_i[DW-1:0];
        gbbc_pkg::CFG_GRID_ROWS: rows_q      <= cfg_data_i[DW-1:0];
        gbbc_pkg::CFG_THRESHOLD: thr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture, candidates scaled to level 0
  logic [gbbc_pkg::KIND_W-1:0]  kind_q;
  logic [PW-1:0]                sx_q, sy_q;
  logic [gbbc_pkg::LEVEL_W-1:0] lvl_q;
  logic [gbbc_pkg::SCORE_W-1:0] score_q;
  logic [gbbc_pkg::CELL_W-1:0]  ci_q;
  logic                         skip_q;

  logic [gbbc_pkg::SHIFT_W-1:0] sx_wide, sy_wide;
  logic                         is_cand, lvl_ok, skip_d;

  always_comb begin
    is_cand = (item_i.kind == gbbc_pkg::KIND_CAND);
    sx_wide = {7'd0, item_i.pos_x};
    sy_wide = {7'd0, item_i.pos_y};
    if (is_cand) begin
      sx_wide = {7'd0, item_i.pos_x} << item_i.level;
      sy_wide = {7'd0, item_i.pos_y} << item_i.level;
    end
    lvl_ok = ({1'b0, item_i.level} < 4'(MAX_LEVELS));
    skip_d = is_cand && (!lvl_ok || (|sx_wide[gbbc_pkg::SHIFT_W-1:PW])
                                 || (|sy_wide[gbbc_pkg::SHIFT_W-1:PW]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= item_i.kind;
      sx_q    <= sx_wide[PW-1:0];
      sy_q    <= sy_wide[PW-1:0];
      lvl_q   <= item_i.level;
      score_q <= item_i.score;
      ci_q    <= item_i.cell_index;
      skip_q  <= skip_d;
    end
  end

  // restoring divider, x and y lanes side by side, one quotient bit a step
  logic [PW-1:0]                dvx_q, dvy_q;
  logic [SW-1:0]                remx_q, remy_q;
  logic [gbbc_pkg::DIV_CW-1:0]  div_cnt_q;
  logic [SW-1:0]                side;
  logic [SW:0]                  trial_x, trial_y;
  logic                         ge_x, ge_y;
  logic [SW-1:0]                remx_n, remy_n;

  always_comb begin
    side    = (cell_size_q == '0) ? SW'(1) : cell_size_q;
    trial_x = {remx_q, dvx_q[PW-1]};
    trial_y = {remy_q, dvy_q[PW-1]};
    ge_x    = (trial_x >= {1'b0, side});
    ge_y    = (trial_y >= {1'b0, side});
    remx_n  = ge_x ? SW'(trial_x - {1'b0, side}) : trial_x[SW-1:0];
    remy_n  = ge_y ? SW'(trial_y - {1'b0, side}) : trial_y[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvx_q  <= sx_wide[PW-1:0];
      dvy_q  <= sy_wide[PW-1:0];
      remx_q <= '0;
      remy_q <= '0;
    end else if (cmd_i.div_step) begin
      dvx_q  <= {dvx_q[PW-2:0], ge_x};
      dvy_q  <= {dvy_q[PW-2:0], ge_y};
      remx_q <= remx_n;
      remy_q <= remy_n;
    end
  end

  // cell number and bounds
  logic [IW-1:0] idx_q, area_q;
  logic          hitpre_q;
  logic          is_read, in_grid;
  logic [IW-1:0] prod, idx_cell, area;

  always_comb begin
    is_read  = (kind_q == gbbc_pkg::KIND_READ);
    in_grid  = (dvx_q < {5'd0, cols_q}) && (dvy_q < {5'd0, rows_q});
    prod     = {7'd0, dvy_q[DW-1:0]} * {7'd0, cols_q};
    idx_cell = prod + {7'd0, dvx_q[DW-1:0]};
    area     = {7'd0, cols_q} * {7'd0, rows_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_index) begin
      idx_q    <= is_read ? {4'd0, ci_q} : idx_cell;
      hitpre_q <= is_read ? 1'b1 : (in_grid && !skip_q);
      area_q   <= area;
    end
  end

  // cell memory, swept to zero after reset
  gbbc_pkg::entry_t cell_mem_q [MAX_CELLS];
  gbbc_pkg::entry_t rdata_q;
  logic             hit_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             hit_d;

  assign hit_d = (is_read ? (idx_q < area_q) : hitpre_q) && (idx_q < IW'(MAX_CELLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      rdata_q <= cell_mem_q[idx_q[AW-1:0]];
      hit_q   <= hit_d;
    end
  end

  gbbc_pkg::entry_t wdata;
  logic             we, better, found;

  always_comb begin
    better = rdata_q.best_valid ? (score_q > rdata_q.score) : (score_q > thr_q);
    found  = hit_q && rdata_q.best_valid && (rdata_q.score > thr_q);
    wdata  = rdata_q;
    we     = 1'b0;
    case (kind_q)
      gbbc_pkg::KIND_MARK: begin
        we             = hit_q;
        wdata.occupied = 1'b1;
      end
      gbbc_pkg::KIND_CAND: begin
        we               = hit_q && !rdata_q.occupied && better;
        wdata.best_valid = 1'b1;
        wdata.x          = sx_q;
        wdata.y          = sy_q;
        wdata.level      = lvl_q;
        wdata.score      = score_q;
      end
      gbbc_pkg::KIND_READ: begin
        we               = hit_q;
        wdata.occupied   = 1'b0;
        wdata.best_valid = 1'b0;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      cell_mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.commit && we) begin
      cell_mem_q[idx_q[AW-1:0]] <= wdata;
    end
  end

  // result register
  logic              out_valid_q;
  gbbc_pkg::result_t out_q;
  gbbc_pkg::result_t out_d;
  logic              emit;

  assign emit = cmd_i.commit && is_read;

  // an empty cell reports an all-zero corner
  always_comb begin
    out_d = '0;
    if (found) begin
      out_d.found        = 1'b1;
      out_d.corner_x     = rdata_q.x;
      out_d.corner_y     = rdata_q.y;
      out_d.corner_level = rdata_q.level;
      out_d.corner_score = rdata_q.score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign result_o    = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o            = '0;
    sts_o.div_last   = (div_cnt_q == gbbc_pkg::DIV_CW'(gbbc_pkg::DIV_STEPS - 1));
    sts_o.clear_last = (clr_cnt_q == AW'(MAX_CELLS - 1));
    sts_o.out_busy   = out_valid_q && !out_ready_i;
    sts_o.is_read    = is_read;
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before taken");

  // divider never steps beyond the quotient width
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> div_cnt_q < gbbc_pkg::DIV_CW'(gbbc_pkg::DIV_STEPS))
    else $error("divider overran");

  // an empty result carries a zero corner
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.corner_score == '0 && out_q.corner_x == '0
                                   && out_q.corner_y == '0 && out_q.corner_level == '0)
    else $error("empty result with payload");

endmodule

`default_nettype wire

/* sv/grid_bucket_best_corner_top.sv */
// top level of the grid bucket best corner block
`default_nettype none

// Keeps the best corner of each square image cell in a grid of up to MAX_CELLS
// cells. Requests are handled one at a time. A mark or candidate request is
// accepted, goes through the bit-serial divider that maps x and y to column
// and row side by side, then through the cell number, the cell memory read
// and the update steps. A read request skips the divider, and a request of
// unknown kind is only accepted. A read result sits in an output register,
// so the next request is accepted while it waits; only a second read stalls at
// its update step until the first result is taken. After reset a clearing
// pass writes every cell entry to zero, during which no request is accepted;
// configuration writes are taken at any time.
module grid_bucket_best_corner_top #(
  parameter int unsigned MAX_CELLS  = 1024,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gbbc_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire logic [gbbc_pkg::CFG_W-1:0]    cfg_data_i,
  gbbc_in_if.sink                            in_i,
  gbbc_out_if.source                         out_o
);

  gbbc_pkg::cmd_t    cmd;
  gbbc_pkg::sts_t    sts;
  gbbc_pkg::item_t   item;
  gbbc_pkg::result_t result;
  logic              in_ready;
  logic              out_valid;

  // request fields gathered into one item
  always_comb begin
    item.kind       = in_i.kind;
    item.pos_x      = in_i.pos_x;
    item.pos_y      = in_i.pos_y;
    item.level      = in_i.level;
    item.score      = in_i.score;
    item.cell_index = in_i.cell_index;
  end

  // controller sees the handshake, the request kind and the datapath status
  gbbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // datapath holds the configuration, divider, cell memory and result
  gbbc_dp #(
    .MAX_CELLS  (MAX_CELLS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.found        = result.found;
  assign out_o.corner_x     = result.corner_x;
  assign out_o.corner_y     = result.corner_y;
  assign out_o.corner_level = result.corner_level;
  assign out_o.corner_score = result.corner_score;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench of the grid bucket best corner block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CELLS      = 1024;
  localparam int unsigned MAX_LEVELS     = 8;
  // a mark or candidate request gives no result, so its pass is waited out
  localparam int unsigned DRAIN_CYCLES   = 24;
  // long receiver hold-off so that the result register fills and input stalls
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned N_DIRECTED     = 25;
  localparam int unsigned N_PHASES       = 9;
  localparam int unsigned PRESSURE_PHASE = 7;
  localparam int unsigned MAX_REPORTS    = 10;

  // the one request kind that the block has no meaning for
  localparam logic [gbbc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam gbbc_pkg::result_t NO_CORNER = '0;

  // one row of the directed part: the request and, where it is obvious,
  // the result it must give
  typedef struct packed {
    gbbc_pkg::item_t   req;
    logic              typed;
    gbbc_pkg::result_t res;
  } row_t;

  // travels with every request, in order of issue
  typedef struct packed {
    logic              typed;
    gbbc_pkg::result_t res;
  } tag_t;

  typedef struct {
    logic [gbbc_pkg::SIZE_W-1:0]  side;
    logic [gbbc_pkg::DIM_W-1:0]   cols;
    logic [gbbc_pkg::DIM_W-1:0]   rows;
    logic [gbbc_pkg::SCORE_W-1:0] thresh;
    int unsigned                  n_items;
  } phase_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [gbbc_pkg::CFG_IW-1:0]   cfg_index_i;
  logic [gbbc_pkg::CFG_W-1:0]    cfg_data_i;

  gbbc_in_if  req_if ();
  gbbc_out_if res_if ();

  grid_bucket_best_corner_top #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_LEVELS(MAX_LEVELS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  always #4 clk_i = ~clk_i;

  // our own picture of the registers and of every cell
  logic [gbbc_pkg::SIZE_W-1:0]  cfg_side;
  logic [gbbc_pkg::DIM_W-1:0]   cfg_cols;
  logic [gbbc_pkg::DIM_W-1:0]   cfg_rows;
  logic [gbbc_pkg::SCORE_W-1:0] cfg_thresh;

  logic                         cell_taken    [MAX_CELLS];
  logic                         cell_has_best [MAX_CELLS];
  logic [gbbc_pkg::POS_W-1:0]   cell_x        [MAX_CELLS];
  logic [gbbc_pkg::POS_W-1:0]   cell_y        [MAX_CELLS];
  logic [gbbc_pkg::LEVEL_W-1:0] cell_lvl      [MAX_CELLS];
  logic [gbbc_pkg::SCORE_W-1:0] cell_score    [MAX_CELLS];

  gbbc_pkg::result_t due_corners [$];
  tag_t              req_tags    [$];
  int unsigned       fault_count = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on     = 1'b1;
  bit                hold_req    = 1'b0;

  // last level-0 corner position handed out, so that later requests revisit
  // the same cell
  int unsigned last_x0 = 0;
  int unsigned last_y0 = 0;

  row_t   directed [N_DIRECTED];
  phase_t phases   [N_PHASES];

  // level-0 pixel to cell number, zero side counts as one
  function automatic bit map_to_cell(input int unsigned x, input int unsigned y,
                                     output int unsigned cell_no);
    int unsigned side;
    int unsigned col;
    int unsigned row;
    side = (cfg_side == 0) ? 1 : cfg_side;
    col  = x / side;
    row  = y / side;
    cell_no = 0;
    if (col >= cfg_cols || row >= cfg_rows) return 1'b0;
    cell_no = row * cfg_cols + col;
    return cell_no < MAX_CELLS;
  endfunction

  // applies one accepted request to the cell picture and works out its result
  function automatic void bucket_request(input gbbc_pkg::item_t req, output logic has_res,
                                         output gbbc_pkg::result_t res);
    int unsigned sx;
    int unsigned sy;
    int unsigned cell_no;
    int unsigned n_area;
    has_res = 1'b0;
    res     = NO_CORNER;
    n_area  = int'(cfg_cols) * int'(cfg_rows);
    case (req.kind)
      gbbc_pkg::KIND_MARK: begin
        if (map_to_cell(req.pos_x, req.pos_y, cell_no)) cell_taken[cell_no] = 1'b1;
      end
      gbbc_pkg::KIND_CAND: begin
        sx = int'(req.pos_x) << req.level;
        sy = int'(req.pos_y) << req.level;
        // too high a level, or a scaled position that cannot be stored
        if (req.level < MAX_LEVELS && sx <= 4095 && sy <= 4095 &&
            map_to_cell(sx, sy, cell_no) && !cell_taken[cell_no]) begin
          if (cell_has_best[cell_no] ? (req.score > cell_score[cell_no])
                                     : (req.score > cfg_thresh)) begin
            cell_has_best[cell_no] = 1'b1;
            cell_x[cell_no]        = gbbc_pkg::POS_W'(sx);
            cell_y[cell_no]        = gbbc_pkg::POS_W'(sy);
            cell_lvl[cell_no]      = req.level;
            cell_score[cell_no]    = req.score;
          end
        end
      end
      gbbc_pkg::KIND_READ: begin
        has_res = 1'b1;
        // a cell beyond the grid reads as empty and changes nothing
        if (int'(req.cell_index) < n_area && req.cell_index < MAX_CELLS) begin
          // found is judged against the threshold of today, not of the write
          if (cell_has_best[req.cell_index] && cell_score[req.cell_index] > cfg_thresh)
            res = {1'b1, cell_x[req.cell_index], cell_y[req.cell_index],
                   cell_lvl[req.cell_index], cell_score[req.cell_index]};
          cell_has_best[req.cell_index] = 1'b0;
          cell_taken[req.cell_index]    = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic row_t cand_row(input int unsigned x, input int unsigned y,
                                    input int unsigned lvl,
                                    input logic [gbbc_pkg::SCORE_W-1:0] s);
    row_t r;
    r = '0;
    r.req.kind  = gbbc_pkg::KIND_CAND;
    r.req.pos_x = gbbc_pkg::POS_W'(x);
    r.req.pos_y = gbbc_pkg::POS_W'(y);
    r.req.level = gbbc_pkg::LEVEL_W'(lvl);
    r.req.score = s;
    return r;
  endfunction

  function automatic row_t mark_row(input int unsigned x, input int unsigned y);
    row_t r;
    r = '0;
    r.req.kind  = gbbc_pkg::KIND_MARK;
    r.req.pos_x = gbbc_pkg::POS_W'(x);
    r.req.pos_y = gbbc_pkg::POS_W'(y);
    return r;
  endfunction

  function automatic row_t read_miss_row(input int unsigned ci);
    row_t r;
    r = '0;
    r.req.kind       = gbbc_pkg::KIND_READ;
    r.req.cell_index = gbbc_pkg::CELL_W'(ci);
    r.typed          = 1'b1;
    return r;
  endfunction

  function automatic row_t read_hit_row(input int unsigned ci, input int unsigned x,
                                        input int unsigned y, input int unsigned lvl,
                                        input logic [gbbc_pkg::SCORE_W-1:0] s);
    row_t r;
    r = read_miss_row(ci);
    r.res = {1'b1, gbbc_pkg::POS_W'(x), gbbc_pkg::POS_W'(y), gbbc_pkg::LEVEL_W'(lvl), s};
    return r;
  endfunction

  // random request shaped by the current grid: most land inside it and
  // revisit recent cells, the rest is noise
  function automatic gbbc_pkg::item_t random_request();
    gbbc_pkg::item_t  req;
    int unsigned      side;
    int unsigned      span_x;
    int unsigned      span_y;
    int unsigned      n_cells;
    int unsigned      pick;
    longint unsigned  sum;
    req.kind       = gbbc_pkg::KIND_W'($urandom);
    req.pos_x      = gbbc_pkg::POS_W'($urandom);
    req.pos_y      = gbbc_pkg::POS_W'($urandom);
    req.level      = gbbc_pkg::LEVEL_W'($urandom);
    req.score      = $urandom;
    req.cell_index = gbbc_pkg::CELL_W'($urandom);
    side   = (cfg_side == 0) ? 1 : cfg_side;
    span_x = cfg_cols * side;
    span_y = cfg_rows * side;
    if (span_x == 0 || span_x > 4096) span_x = 4096;
    if (span_y == 0 || span_y > 4096) span_y = 4096;
    n_cells = cfg_cols * cfg_rows;
    if (n_cells == 0 || n_cells > MAX_CELLS) n_cells = MAX_CELLS;
    pick = $urandom_range(0, 99);
    if (pick < 12) return req;
    if (pick < 30) begin
      req.kind = gbbc_pkg::KIND_MARK;
      if ($urandom_range(0, 2) == 0) begin
        req.pos_x = gbbc_pkg::POS_W'(last_x0);
        req.pos_y = gbbc_pkg::POS_W'(last_y0);
      end else begin
        req.pos_x = gbbc_pkg::POS_W'($urandom_range(0, span_x - 1));
        req.pos_y = gbbc_pkg::POS_W'($urandom_range(0, span_y - 1));
      end
    end else if (pick < 65) begin
      req.kind  = gbbc_pkg::KIND_CAND;
      req.level = ($urandom_range(0, 3) == 0) ? gbbc_pkg::LEVEL_W'($urandom_range(0, 7))
                                              : gbbc_pkg::LEVEL_W'($urandom_range(0, 2));
      // one in ten keeps its raw position, which may scale past the limit
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 2) != 0) begin
          last_x0 = $urandom_range(0, span_x - 1);
          last_y0 = $urandom_range(0, span_y - 1);
        end
        req.pos_x = gbbc_pkg::POS_W'(last_x0 >> req.level);
        req.pos_y = gbbc_pkg::POS_W'(last_y0 >> req.level);
      end
      case ($urandom_range(0, 3))
        0: req.score = $urandom;
        1: begin
          sum = longint'(cfg_thresh) + 1;
          req.score = (sum > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : gbbc_pkg::SCORE_W'(sum);
        end
        2: begin
          sum = longint'(cfg_thresh) + $urandom_range(0, 5000);
          req.score = (sum > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : gbbc_pkg::SCORE_W'(sum);
        end
        default: begin
          req.score = (cfg_thresh > 3000) ? cfg_thresh - $urandom_range(0, 3000)
                                          : $urandom_range(0, 3000);
        end
      endcase
    end else begin
      req.kind = gbbc_pkg::KIND_READ;
      pick = (last_y0 / side) * cfg_cols + last_x0 / side;
      if ($urandom_range(0, 4) == 0) begin
        req.cell_index = gbbc_pkg::CELL_W'($urandom);
      end else if ($urandom_range(0, 1) == 0 && pick < MAX_CELLS) begin
        req.cell_index = gbbc_pkg::CELL_W'(pick);
      end else begin
        req.cell_index = gbbc_pkg::CELL_W'($urandom_range(0, n_cells - 1));
      end
    end
    return req;
  endfunction

  task automatic note_fault(input string what, input gbbc_pkg::result_t want,
                            input gbbc_pkg::result_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display({"mismatch, %s: expected found %0b x %0d y %0d level %0d score %h,",
                " got found %0b x %0d y %0d level %0d score %h"},
               what, want.found, want.corner_x, want.corner_y, want.corner_level,
               want.corner_score, got.found, got.corner_x, got.corner_y,
               got.corner_level, got.corner_score);
  endtask

  // offers one request and returns at the edge that takes it, valid still high
  task automatic send_item(input gbbc_pkg::item_t req, input logic typed,
                           input gbbc_pkg::result_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_tags.insert(req_tags.size(), {typed, res});
    req_if.valid      <= 1'b1;
    req_if.kind       <= req.kind;
    req_if.pos_x      <= req.pos_x;
    req_if.pos_y      <= req.pos_y;
    req_if.level      <= req.level;
    req_if.score      <= req.score;
    req_if.cell_index <= req.cell_index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stops offering, waits for every due result and lets the last mark or
  // candidate finish its pass through the divider
  task automatic drain_block();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_corners.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gbbc_pkg::CFG_IW-1:0] idx,
                           input logic [gbbc_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      gbbc_pkg::CFG_CELL_SIZE: cfg_side   = value[gbbc_pkg::SIZE_W-1:0];
      gbbc_pkg::CFG_GRID_COLS: cfg_cols   = value[gbbc_pkg::DIM_W-1:0];
      gbbc_pkg::CFG_GRID_ROWS: cfg_rows   = value[gbbc_pkg::DIM_W-1:0];
      gbbc_pkg::CFG_THRESHOLD: cfg_thresh = value[gbbc_pkg::SCORE_W-1:0];
      default: ;
    endcase
  endtask

  // accepted requests go through the predictor; rows with a typed-in result
  // use that one instead
  gbbc_pkg::item_t   seen_req;
  tag_t              seen_tag;
  logic              seen_has;
  gbbc_pkg::result_t seen_res;

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      seen_req = {req_if.kind, req_if.pos_x, req_if.pos_y, req_if.level, req_if.score,
                  req_if.cell_index};
      seen_tag = req_tags.pop_front();
      bucket_request(seen_req, seen_has, seen_res);
      if (seen_has)
        due_corners.insert(due_corners.size(), seen_tag.typed ? seen_tag.res : seen_res);
    end
  end

  // every result taken is held against the oldest one due
  gbbc_pkg::result_t got_res;
  gbbc_pkg::result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_res = {res_if.found, res_if.corner_x, res_if.corner_y, res_if.corner_level,
                 res_if.corner_score};
      if (due_corners.size() == 0) begin
        note_fault("result with none due", NO_CORNER, got_res);
      end else begin
        want_res = due_corners.pop_front();
        if (got_res.found !== want_res.found || got_res.corner_x !== want_res.corner_x ||
            got_res.corner_y !== want_res.corner_y ||
            got_res.corner_level !== want_res.corner_level ||
            got_res.corner_score !== want_res.corner_score)
          note_fault("wrong result", want_res, got_res);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none at the end
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_bucket_best_corner_top test failed");
      $finish;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= gbbc_pkg::CFG_CELL_SIZE;
    cfg_data_i        <= '0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= gbbc_pkg::KIND_MARK;
    req_if.pos_x      <= '0;
    req_if.pos_y      <= '0;
    req_if.level      <= '0;
    req_if.score      <= '0;
    req_if.cell_index <= '0;

    cfg_side   = gbbc_pkg::RST_CELL_SIZE;
    cfg_cols   = gbbc_pkg::RST_GRID_COLS;
    cfg_rows   = gbbc_pkg::RST_GRID_ROWS;
    cfg_thresh = gbbc_pkg::RST_THRESHOLD;
    for (int i = 0; i < MAX_CELLS; i++) begin
      cell_taken[i]    = 1'b0;
      cell_has_best[i] = 1'b0;
      cell_x[i]        = '0;
      cell_y[i]        = '0;
      cell_lvl[i]      = '0;
      cell_score[i]    = '0;
    end

    // directed part, under the reset grid of 30 pixel cells, 22 by 16
    directed = '{
      read_miss_row(0),                                  // empty after reset
      read_miss_row(1023),                               // beyond the grid
      cand_row(0, 0, 0, 32'd5121),                       // just over threshold
      read_hit_row(0, 0, 0, 0, 32'd5121),
      cand_row(0, 0, 0, 32'd5120),                       // equal is not enough
      read_miss_row(0),
      cand_row(4, 2, 3, 32'hFFFF_FFFF),                  // level 3 lands in cell 1
      read_hit_row(1, 32, 16, 3, 32'hFFFF_FFFF),
      mark_row(45, 0),                                   // occupied cell skips
      cand_row(40, 5, 0, 32'd10000),
      read_miss_row(1),
      cand_row(70, 0, 0, 32'd9000),                      // mark after candidate
      mark_row(65, 10),
      read_hit_row(2, 70, 0, 0, 32'd9000),
      cand_row(95, 3, 0, 32'd6000),                      // best score wins, ties lose
      cand_row(100, 4, 0, 32'd7000),
      cand_row(110, 5, 0, 32'd6500),
      cand_row(111, 6, 0, 32'd7000),
      read_hit_row(3, 100, 4, 0, 32'd7000),
      {KIND_SPARE, 12'hFFF, 12'hFFF, 3'h7, 32'hFFFF_FFFF, 10'h3FF, 1'b0, NO_CORNER},
      cand_row(4095, 4095, 7, 32'hFFFF_FFFF),            // scaled far past 4095
      mark_row(4095, 4095),                              // outside the grid
      cand_row(659, 479, 0, 32'd5200),                   // last cell of the grid
      read_hit_row(351, 659, 479, 0, 32'd5200),
      read_miss_row(352)                                 // first cell past it
    };

    // settings walked by the random part; the cell picture carries over, so
    // reads after a change see stored corners against a new threshold
    phases = '{
      '{8'd30,  7'd22,  7'd16,  32'd5120,       60},
      '{8'd1,   7'd64,  7'd16,  32'd0,          60},
      '{8'd255, 7'd64,  7'd64,  32'hFFFF_FFFF,  40},
      '{8'd0,   7'd127, 7'd127, 32'd200,        60},   // zero side acts as one
      '{8'd8,   7'd7,   7'd5,   32'd1000,       60},
      '{8'd13,  7'd1,   7'd1,   32'd0,          40},
      '{8'd30,  7'd0,   7'd16,  32'd0,          20},   // no columns at all
      '{8'd20,  7'd40,  7'd30,  32'd3000,       80},
      '{8'd16,  7'd33,  7'd20,  32'd4000,       80}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block runs its clearing pass first; send_item waits for ready
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed[i].req, directed[i].typed, directed[i].res);
    drain_block();

    for (int p = 0; p < N_PHASES; p++) begin
      // narrow registers get random upper bits that must be dropped
      write_reg(gbbc_pkg::CFG_CELL_SIZE, ($urandom & 32'hFFFF_FF00) | 32'(phases[p].side));
      write_reg(gbbc_pkg::CFG_GRID_COLS, ($urandom & 32'hFFFF_FF80) | 32'(phases[p].cols));
      write_reg(gbbc_pkg::CFG_GRID_ROWS, ($urandom & 32'hFFFF_FF80) | 32'(phases[p].rows));
      write_reg(gbbc_pkg::CFG_THRESHOLD, phases[p].thresh);
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      if (p == N_PHASES - 1) idle_on = 1'b0;
      repeat (phases[p].n_items) send_item(random_request(), 1'b0, NO_CORNER);
      drain_block();
    end

    if (fault_count == 0 && due_corners.size() == 0) begin
      $display("grid_bucket_best_corner_top test passed");
    end else begin
      $display("grid_bucket_best_corner_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/gbbc_pkg.sv
sv/gbbc_if.sv
sv/gbbc_ctrl.sv
sv/gbbc_dp.sv
sv/grid_bucket_best_corner_top.sv
tb/sv/tb.sv
